// File: hdl/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg: shared types and constants of the backprop trainer
// Network sizes, fixed-point helpers, sigmoid table and sequencer control.
// ----------------------------------------------------------------------------
`default_nettype none

package mbt_pkg;

   localparam int IN_NODES     = 4;
   localparam int HIDDEN_NODES = 10;
   localparam int OUT_NODES    = 3;

   localparam int N_IW      = IN_NODES * HIDDEN_NODES;
   localparam int N_OW      = HIDDEN_NODES * OUT_NODES;
   localparam int N_HB_BASE = N_IW + N_OW;
   localparam int N_OB_BASE = N_HB_BASE + HIDDEN_NODES;

   localparam int LANE_W = (HIDDEN_NODES > 1) ? $clog2(HIDDEN_NODES) : 1;
   localparam int CNT_W  = 2;
   localparam int PROD_W = 41;
   localparam int SUM_W  = PROD_W + LANE_W + 1;

   localparam logic [15:0] RATE_RESET = 16'd29491;

   localparam logic [1:0] REQ_TRAIN = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   localparam logic [1:0] CSR_RATE_IW = 2'd0;
   localparam logic [1:0] CSR_RATE_OW = 2'd1;
   localparam logic [1:0] CSR_RATE_HB = 2'd2;
   localparam logic [1:0] CSR_RATE_OB = 2'd3;

   localparam logic signed [63:0] W_MAX = 64'sd8388607;
   localparam logic signed [63:0] W_MIN = -64'sd8388608;

   typedef logic [IN_NODES-1:0][15:0]         feature_type;
   typedef logic [OUT_NODES-1:0][15:0]        target_type;
   typedef logic [OUT_NODES-1:0][31:0]        qo_type;
   typedef logic [HIDDEN_NODES-1:0][PROD_W-1:0] prod_bus_type;
   typedef logic [2:0][15:0]                  res_type;
   typedef logic [1023:0][15:0]               sig_table_type;

   typedef enum logic [3:0] {
      L_NOP, L_WRITE, L_HMAC, L_HACT, L_OPROD, L_OWT, L_OWU,
      L_HDMAC, L_HDA, L_HDB, L_IWT, L_IWU, L_HBU
   } lane_op_type;

   typedef enum logic [2:0] {
      M_NOP, M_WRITE, M_CLR, M_OSUM, M_DA, M_DB, M_OBU
   } merge_op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_WRITE, ST_HMAC, ST_HACT, ST_OPROD, ST_OSUM,
      ST_DA, ST_DB, ST_OWT, ST_OWU, ST_HDMAC, ST_HDA, ST_HDB,
      ST_IWT, ST_IWU, ST_BIAS, ST_DONE
   } state_type;

   typedef struct packed {
      lane_op_type  lane_op;
      merge_op_type merge_op;
      logic [CNT_W-1:0] sel;
      feature_type  feature;
      target_type   target;
      logic [6:0]   windex;
      logic [23:0]  wvalue;
      logic [15:0]  rate_iw;
      logic [15:0]  rate_ow;
      logic [15:0]  rate_hb;
      logic [15:0]  rate_ob;
   } mbt_ctl_type;

   function automatic sig_table_type build_sig_table();
      sig_table_type tab;
      logic [65:0] t;
      logic [65:0] den;
      logic [65:0] num;
      logic [65:0] rem;
      logic [65:0] s;
      logic [65:0] prod;
      tab = '0;
      t = 66'd1 << 32;
      for (int m = 0; m <= 512; m++) begin
         den = (66'd1 << 32) + t;
         num = (66'd1 << 47) + (den >> 1);
         rem = '0;
         s = '0;
         for (int b = 65; b >= 0; b--) begin
            rem = {rem[64:0], num[b]};
            if (rem >= den) begin
               rem = rem - den;
               s[b] = 1'b1;
            end
         end
         if (m < 512) tab[512 + m] = s[15:0];
         if (m > 0) tab[512 - m] = 16'(66'd32768 - s);
         prod = t * 66'd4228380000 + (66'd1 << 31);
         t = prod >> 32;
      end
      return tab;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

   function automatic logic [15:0] sig_lookup(input logic signed [47:0] z);
      logic signed [48:0] t;
      logic [9:0] idx;
      t = 49'(z) + 49'sd524288;
      if (t < 0) idx = '0;
      else if (t[48:20] != '0) idx = '1;
      else idx = t[19:10];
      return SIG_TABLE[idx];
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
      logic signed [23:0] r;
      if (v > W_MAX) r = 24'sh7FFFFF;
      else if (v < W_MIN) r = -24'sd8388608;
      else r = v[23:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/mlp_backprop_trainer_core.sv
// ----------------------------------------------------------------------------
// mlp_backprop_trainer_core: 4-10-3 sigmoid perceptron with online training
// Hidden-node lanes work in parallel under one sequencer; a merging stage
// forms the outputs, output deltas and error.
//
//   channel   direction  handshake              carries
//   req_      in         req_valid / req_stall  request type, features, targets, weight
//   rsp_      out        rsp_valid / rsp_stall  three outputs, sample error
//   csr_      in         csr_valid / csr_ready  rate register index and data
//
// A weight write runs a write step ahead of the inference steps. Training adds
// the per-output and per-input update steps that each lane runs in turn.
// One item at a time; a finished result waits in the output register while
// the next item runs. Reset clears all weights and biases and loads the rates.
// ----------------------------------------------------------------------------
`default_nettype none

module mlp_backprop_trainer_core import mbt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [15:0]        req_feature_a,
   input  logic [15:0]        req_feature_b,
   input  logic [15:0]        req_feature_c,
   input  logic [15:0]        req_feature_d,
   input  logic [15:0]        req_target_a,
   input  logic [15:0]        req_target_b,
   input  logic [15:0]        req_target_c,
   input  logic [6:0]         req_weight_index,
   input  logic signed [23:0] req_weight_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_output_a,
   output logic [15:0]        rsp_output_b,
   output logic [15:0]        rsp_output_c,
   output logic [16:0]        rsp_sample_error,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             load;

   logic [1:0]        type_ff;
   logic [3:0][15:0]  feature_ff;
   logic [2:0][15:0]  target_ff;
   logic [6:0]        windex_ff;
   logic [23:0]       wvalue_ff;
   logic [15:0]       rate_iw_ff, rate_ow_ff, rate_hb_ff, rate_ob_ff;

   logic [15:0] out_a_ff, out_b_ff, out_c_ff;
   logic [16:0] err_ff;

   logic         last_in, last_out;
   mbt_ctl_type  ctl;
   prod_bus_type prods;
   qo_type       qo;
   res_type      y;
   logic [16:0]  err;

   assign last_in  = (cnt_ff == CNT_W'(IN_NODES - 1));
   assign last_out = (cnt_ff == CNT_W'(OUT_NODES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == REQ_WRITE) ? ST_WRITE : ST_HMAC;
               cnt_in   = '0;
            end
         end
         ST_WRITE: state_in = ST_HMAC;
         ST_HMAC: begin
            if (last_in) begin
               state_in = ST_HACT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_HACT:  state_in = ST_OPROD;
         ST_OPROD: state_in = ST_OSUM;
         ST_OSUM: begin
            if (last_out) begin
               state_in = (type_ff == REQ_TRAIN) ? ST_DA : ST_DONE;
               cnt_in   = '0;
            end else begin
               state_in = ST_OPROD;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         ST_DA:  state_in = ST_DB;
         ST_DB:  state_in = ST_OWT;
         ST_OWT: state_in = ST_OWU;
         ST_OWU: begin
            if (last_out) begin
               state_in = ST_HDMAC;
               cnt_in   = '0;
            end else begin
               state_in = ST_DA;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         ST_HDMAC: begin
            if (last_out) begin
               state_in = ST_HDA;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_HDA: state_in = ST_HDB;
         ST_HDB: begin
            state_in = ST_IWT;
            cnt_in   = '0;
         end
         ST_IWT: state_in = ST_IWU;
         ST_IWU: begin
            if (last_in) begin
               state_in = ST_BIAS;
               cnt_in   = '0;
            end else begin
               state_in = ST_IWT;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         ST_BIAS: begin
            if (last_out) begin
               state_in = ST_DONE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);

   always_comb begin
      ctl          = '0;
      ctl.sel      = cnt_ff;
      ctl.windex   = windex_ff;
      ctl.wvalue   = wvalue_ff;
      ctl.rate_iw  = rate_iw_ff;
      ctl.rate_ow  = rate_ow_ff;
      ctl.rate_hb  = rate_hb_ff;
      ctl.rate_ob  = rate_ob_ff;
      for (int i = 0; i < IN_NODES; i++) ctl.feature[i] = feature_ff[i];
      for (int o = 0; o < OUT_NODES; o++) ctl.target[o] = target_ff[o];
      ctl.lane_op  = L_NOP;
      ctl.merge_op = M_NOP;
      case (state_ff)
         ST_WRITE: begin
            ctl.lane_op  = L_WRITE;
            ctl.merge_op = M_WRITE;
         end
         ST_HMAC: begin
            ctl.lane_op  = L_HMAC;
            ctl.merge_op = (cnt_ff == '0) ? M_CLR : M_NOP;
         end
         ST_HACT:  ctl.lane_op  = L_HACT;
         ST_OPROD: ctl.lane_op  = L_OPROD;
         ST_OSUM:  ctl.merge_op = M_OSUM;
         ST_DA:    ctl.merge_op = M_DA;
         ST_DB:    ctl.merge_op = M_DB;
         ST_OWT:   ctl.lane_op  = L_OWT;
         ST_OWU:   ctl.lane_op  = L_OWU;
         ST_HDMAC: ctl.lane_op  = L_HDMAC;
         ST_HDA:   ctl.lane_op  = L_HDA;
         ST_HDB:   ctl.lane_op  = L_HDB;
         ST_IWT:   ctl.lane_op  = L_IWT;
         ST_IWU:   ctl.lane_op  = L_IWU;
         ST_BIAS: begin
            ctl.lane_op  = (cnt_ff == '0) ? L_HBU : L_NOP;
            ctl.merge_op = M_OBU;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         type_ff    <= req_type;
         feature_ff <= {req_feature_d, req_feature_c, req_feature_b, req_feature_a};
         target_ff  <= {req_target_c, req_target_b, req_target_a};
         windex_ff  <= req_weight_index;
         wvalue_ff  <= req_weight_value;
      end
      if (load) begin
         out_a_ff <= y[0];
         out_b_ff <= y[1];
         out_c_ff <= y[2];
         err_ff   <= err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_iw_ff <= RATE_RESET;
         rate_ow_ff <= RATE_RESET;
         rate_hb_ff <= RATE_RESET;
         rate_ob_ff <= RATE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RATE_IW: rate_iw_ff <= csr_data;
            CSR_RATE_OW: rate_ow_ff <= csr_data;
            CSR_RATE_HB: rate_hb_ff <= csr_data;
            CSR_RATE_OB: rate_ob_ff <= csr_data;
            default: ;
         endcase
      end
   end

   genvar g;
   generate
      for (g = 0; g < HIDDEN_NODES; g++) begin : g_lane
         mbt_lane u_lane (
            .clock      (clock),
            .reset      (reset),
            .lane_index (LANE_W'(g)),
            .ctl        (ctl),
            .qo         (qo),
            .prod       (prods[g])
         );
      end
   endgenerate

   mbt_merge u_merge (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .prods (prods),
      .qo    (qo),
      .y     (y),
      .err   (err)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_output_a     = out_a_ff;
   assign rsp_output_b     = out_b_ff;
   assign rsp_output_c     = out_c_ff;
   assign rsp_sample_error = err_ff;
   assign csr_ready        = 1'b1;

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !(rsp_valid_ff && rsp_stall))
         |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not moved to output register");

   a_train_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DA || state_ff == ST_HDMAC || state_ff == ST_BIAS)
         |-> (type_ff == REQ_TRAIN))
      else $error("update step on a non-training item");

   a_write_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (type_ff == REQ_WRITE))
      else $error("weight write on a non-write item");

   a_out_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OSUM || state_ff == ST_OWU) |-> (int'(cnt_ff) < OUT_NODES))
      else $error("output node index out of range");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (load && type_ff != REQ_TRAIN) |=> (rsp_sample_error == '0))
      else $error("error reported on a non-training item");

endmodule

`default_nettype wire

// File: hdl/mbt_lane.sv
// ----------------------------------------------------------------------------
// mbt_lane: one hidden node of the trainer
// Holds the node's input weights, output weights and bias, and steps through
// forward activation, output product, delta and weight updates one op a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_lane import mbt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [LANE_W-1:0]        lane_index,
   input  mbt_ctl_type              ctl,
   input  qo_type                   qo,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [23:0] w_in_ff  [IN_NODES];
   logic signed [23:0] w_in_in  [IN_NODES];
   logic signed [23:0] w_out_ff [OUT_NODES];
   logic signed [23:0] w_out_in [OUT_NODES];
   logic signed [23:0] bias_ff, bias_in;

   logic signed [42:0] acc_ff, acc_in;
   logic signed [57:0] acc2_ff, acc2_in;
   logic [15:0]        h_ff, h_in;
   logic [28:0]        hh_ff, hh_in;
   logic signed [41:0] t_ff, t_in;
   logic signed [39:0] qh_ff, qh_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic signed [16:0] x_s, h_s;
   logic signed [16:0] rate_iw_s, rate_ow_s, rate_hb_s;
   logic signed [31:0] qo_cur;
   logic signed [40:0] hmac_p;
   logic signed [43:0] hact_r;
   logic signed [47:0] hact_z;
   logic signed [40:0] oprod_p;
   logic signed [48:0] owt_p, owt_t;
   logic signed [58:0] owu_p, owu_s;
   logic signed [55:0] hdmac_p;
   logic [31:0]        hda_p;
   logic signed [57:0] hdb_s, hdb_p, hdb_q;
   logic signed [56:0] iwt_p, iwt_t;
   logic signed [58:0] iwu_p, iwu_s;
   logic signed [56:0] hbu_p, hbu_s;

   assign x_s       = $signed({1'b0, ctl.feature[ctl.sel]});
   assign h_s       = $signed({1'b0, h_ff});
   assign rate_iw_s = $signed({1'b0, ctl.rate_iw});
   assign rate_ow_s = $signed({1'b0, ctl.rate_ow});
   assign rate_hb_s = $signed({1'b0, ctl.rate_hb});
   assign qo_cur    = $signed(qo[ctl.sel]);

   assign hmac_p  = w_in_ff[ctl.sel] * x_s;
   assign hact_r  = (44'(acc_ff) + 44'sd16384) >>> 15;
   assign hact_z  = 48'(hact_r) + 48'(bias_ff);
   assign oprod_p = w_out_ff[ctl.sel] * h_s;
   assign owt_p   = qo_cur * h_s;
   assign owt_t   = (owt_p + 49'sd16384) >>> 15;
   assign owu_p   = rate_ow_s * t_ff;
   assign owu_s   = (owu_p + (59'sd1 <<< 28)) >>> 29;
   assign hdmac_p = qo_cur * w_out_ff[ctl.sel];
   assign hda_p   = 32'(h_ff) * 32'(16'd32768 - h_ff);
   assign hdb_s   = (acc2_ff + (58'sd1 <<< 29)) >>> 30;
   assign hdb_p   = 28'(hdb_s) * $signed({1'b0, hh_ff});
   assign hdb_q   = (hdb_p + 58'sd32768) >>> 16;
   assign iwt_p   = qh_ff * x_s;
   assign iwt_t   = (iwt_p + 57'sd16384) >>> 15;
   assign iwu_p   = rate_iw_s * t_ff;
   assign iwu_s   = (iwu_p + (59'sd1 <<< 28)) >>> 29;
   assign hbu_p   = rate_hb_s * qh_ff;
   assign hbu_s   = (hbu_p + (57'sd1 <<< 28)) >>> 29;

   always_comb begin
      w_in_in  = w_in_ff;
      w_out_in = w_out_ff;
      bias_in  = bias_ff;
      acc_in   = acc_ff;
      acc2_in  = acc2_ff;
      h_in     = h_ff;
      hh_in    = hh_ff;
      t_in     = t_ff;
      qh_in    = qh_ff;
      prod_in  = prod_ff;
      case (ctl.lane_op)
         L_WRITE: begin
            for (int i = 0; i < IN_NODES; i++) begin
               if (int'(ctl.windex) == i * HIDDEN_NODES + int'(lane_index))
                  w_in_in[i] = $signed(ctl.wvalue);
            end
            for (int o = 0; o < OUT_NODES; o++) begin
               if (int'(ctl.windex) == N_IW + int'(lane_index) * OUT_NODES + o)
                  w_out_in[o] = $signed(ctl.wvalue);
            end
            if (int'(ctl.windex) == N_HB_BASE + int'(lane_index))
               bias_in = $signed(ctl.wvalue);
         end
         L_HMAC:  acc_in  = ((ctl.sel == '0) ? 43'sd0 : acc_ff) + 43'(hmac_p);
         L_HACT:  h_in    = sig_lookup(hact_z);
         L_OPROD: prod_in = oprod_p;
         L_OWT:   t_in    = 42'(owt_t);
         L_OWU:   w_out_in[ctl.sel] = sat24(64'(w_out_ff[ctl.sel]) + 64'(owu_s));
         L_HDMAC: acc2_in = ((ctl.sel == '0) ? 58'sd0 : acc2_ff) + 58'(hdmac_p);
         L_HDA:   hh_in   = hda_p[28:0];
         L_HDB:   qh_in   = 40'(hdb_q);
         L_IWT:   t_in    = 42'(iwt_t);
         L_IWU:   w_in_in[ctl.sel] = sat24(64'(w_in_ff[ctl.sel]) + 64'(iwu_s));
         L_HBU:   bias_in = sat24(64'(bias_ff) + 64'(hbu_s));
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < IN_NODES; i++) w_in_ff[i] <= '0;
         for (int o = 0; o < OUT_NODES; o++) w_out_ff[o] <= '0;
         bias_ff <= '0;
      end else begin
         w_in_ff  <= w_in_in;
         w_out_ff <= w_out_in;
         bias_ff  <= bias_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      acc2_ff <= acc2_in;
      h_ff    <= h_in;
      hh_ff   <= hh_in;
      t_ff    <= t_in;
      qh_ff   <= qh_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// File: hdl/mbt_merge.sv
// ----------------------------------------------------------------------------
// mbt_merge: output layer of the trainer
// Sums the lane products, holds output biases, outputs, output deltas and the
// squared error.
// ----------------------------------------------------------------------------
`default_nettype none

module mbt_merge import mbt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  mbt_ctl_type  ctl,
   input  prod_bus_type prods,
   output qo_type       qo,
   output res_type      y,
   output logic [16:0]  err
);

   logic signed [23:0] ob_ff [OUT_NODES];
   logic signed [23:0] ob_in [OUT_NODES];
   logic [15:0]        y_ff  [OUT_NODES];
   logic [15:0]        y_in  [OUT_NODES];
   logic signed [31:0] qo_ff [OUT_NODES];
   logic signed [31:0] qo_in [OUT_NODES];
   logic signed [17:0] diff_ff, diff_in;
   logic [28:0]        a_ff, a_in;
   logic [35:0]        err_ff, err_in;

   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] sum_r;
   logic signed [47:0]      z_o;
   logic [31:0]             a_p;
   logic signed [47:0]      db_p, db_q;
   logic signed [35:0]      sq_p;
   logic signed [16:0]      rate_ob_s;
   logic signed [48:0]      obu_p, obu_s;
   logic [20:0]             err_r;

   always_comb begin
      sum = '0;
      for (int h = 0; h < HIDDEN_NODES; h++)
         sum = sum + SUM_W'($signed(prods[h]));
   end

   assign sum_r     = (sum + SUM_W'(16384)) >>> 15;
   assign z_o       = 48'(sum_r) + 48'(ob_ff[ctl.sel]);
   assign a_p       = 32'(y_ff[ctl.sel]) * 32'(16'd32768 - y_ff[ctl.sel]);
   assign db_p      = diff_ff * $signed({1'b0, a_ff});
   assign db_q      = (db_p + 48'sd16384) >>> 15;
   assign sq_p      = diff_ff * diff_ff;
   assign rate_ob_s = $signed({1'b0, ctl.rate_ob});
   assign obu_p     = rate_ob_s * qo_ff[ctl.sel];
   assign obu_s     = (obu_p + (49'sd1 <<< 28)) >>> 29;
   assign err_r     = 21'((err_ff + 36'd16384) >> 15);

   always_comb begin
      ob_in   = ob_ff;
      y_in    = y_ff;
      qo_in   = qo_ff;
      diff_in = diff_ff;
      a_in    = a_ff;
      err_in  = err_ff;
      case (ctl.merge_op)
         M_WRITE: begin
            for (int o = 0; o < OUT_NODES; o++) begin
               if (int'(ctl.windex) == N_OB_BASE + o) ob_in[o] = $signed(ctl.wvalue);
            end
         end
         M_CLR:  err_in = '0;
         M_OSUM: y_in[ctl.sel] = sig_lookup(z_o);
         M_DA: begin
            diff_in = $signed({2'b00, ctl.target[ctl.sel]}) - $signed({2'b00, y_ff[ctl.sel]});
            a_in    = a_p[28:0];
         end
         M_DB: begin
            qo_in[ctl.sel] = 32'(db_q);
            err_in         = err_ff + $unsigned(sq_p);
         end
         M_OBU:  ob_in[ctl.sel] = sat24(64'(ob_ff[ctl.sel]) + 64'(obu_s));
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int o = 0; o < OUT_NODES; o++) ob_ff[o] <= '0;
      end else begin
         ob_ff <= ob_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      qo_ff   <= qo_in;
      diff_ff <= diff_in;
      a_ff    <= a_in;
      err_ff  <= err_in;
   end

   genvar k;
   generate
      for (k = 0; k < OUT_NODES; k++) begin : g_qo
         assign qo[k] = qo_ff[k];
      end
      for (k = 0; k < 3; k++) begin : g_y
         if (k < OUT_NODES) begin : g_used
            assign y[k] = y_ff[k];
         end else begin : g_pad
            assign y[k] = '0;
         end
      end
   endgenerate

   assign err = (err_r > 21'd131071) ? 17'd131071 : err_r[16:0];

endmodule

`default_nettype wire

// File: verif/mbt_checker.sv
// ----------------------------------------------------------------------------
// mbt_checker: result predictor and scoreboard for the backprop trainer
// Watches the request, response and rate-register channels, keeps its own
// copy of the weights, biases and rates, works out the outputs and sample
// error of each accepted request and compares them with the responses.
// ----------------------------------------------------------------------------
module mbt_checker import mbt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [15:0]        req_feature_a,
   input  logic [15:0]        req_feature_b,
   input  logic [15:0]        req_feature_c,
   input  logic [15:0]        req_feature_d,
   input  logic [15:0]        req_target_a,
   input  logic [15:0]        req_target_b,
   input  logic [15:0]        req_target_c,
   input  logic [6:0]         req_weight_index,
   input  logic signed [23:0] req_weight_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [15:0]        rsp_output_a,
   input  logic [15:0]        rsp_output_b,
   input  logic [15:0]        rsp_output_c,
   input  logic [16:0]        rsp_sample_error,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 errors,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] out_a;
      logic [15:0] out_b;
      logic [15:0] out_c;
      logic [16:0] sq_err;
   } net_result_type;

   net_result_type expected_q[$];
   logic [15:0]  act_lut[1024];
   longint       w_in[N_IW];
   longint       w_out[N_OW];
   longint       b_hid[HIDDEN_NODES];
   longint       b_out[OUT_NODES];
   logic [15:0]  rate_iw, rate_ow, rate_hb, rate_ob;

   initial begin
      longint unsigned t, den, s;
      errors = 0;
      pending = 0;
      t = 64'd1 << 32;
      for (int m = 0; m <= 512; m++) begin
         den = (64'd1 << 32) + t;
         s = ((64'd1 << 47) + den / 2) / den;
         if (m < 512) act_lut[512 + m] = s[15:0];
         if (m > 0) act_lut[512 - m] = 16'(64'd32768 - s);
         t = (t * 64'd4228380000 + (64'd1 << 31)) >> 32;
      end
   end

   function automatic longint rshift_rnd(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint squash(longint z);
      longint idx;
      if (z < -524288) return act_lut[0];
      idx = (z + 524288) >>> 10;
      if (idx > 1023) idx = 1023;
      return act_lut[idx];
   endfunction

   function automatic longint clip_w(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint w_step(longint rate, longint d, longint a);
      return rshift_rnd(rate * rshift_rnd(d * a, 15), 29);
   endfunction

   task automatic store_weight(int idx, longint v);
      if (idx < N_IW) w_in[idx] = v;
      else if (idx < N_HB_BASE) w_out[idx - N_IW] = v;
      else if (idx < N_OB_BASE) b_hid[idx - N_HB_BASE] = v;
      else if (idx < N_OB_BASE + OUT_NODES) b_out[idx - N_OB_BASE] = v;
   endtask

   task automatic predict_request();
      longint      x[IN_NODES], tg[OUT_NODES], h[HIDDEN_NODES], y[OUT_NODES];
      longint      qo[OUT_NODES], qh[HIDDEN_NODES], acc, diff, err;
      net_result_type r;
      x = '{longint'(req_feature_a), longint'(req_feature_b),
            longint'(req_feature_c), longint'(req_feature_d)};
      tg = '{longint'(req_target_a), longint'(req_target_b), longint'(req_target_c)};
      err = 0;
      if (req_type == REQ_WRITE) store_weight(int'(req_weight_index), longint'(req_weight_value));
      for (int j = 0; j < HIDDEN_NODES; j++) begin
         acc = 0;
         for (int i = 0; i < IN_NODES; i++) acc += w_in[i * HIDDEN_NODES + j] * x[i];
         h[j] = squash(rshift_rnd(acc, 15) + b_hid[j]);
      end
      for (int j = 0; j < OUT_NODES; j++) begin
         acc = 0;
         for (int i = 0; i < HIDDEN_NODES; i++) acc += w_out[i * OUT_NODES + j] * h[i];
         y[j] = squash(rshift_rnd(acc, 15) + b_out[j]);
      end
      if (req_type == REQ_TRAIN) begin
         for (int j = 0; j < OUT_NODES; j++) begin
            diff = tg[j] - y[j];
            qo[j] = rshift_rnd(diff * (y[j] * (32768 - y[j])), 15);
            err += diff * diff;
            for (int i = 0; i < HIDDEN_NODES; i++)
               w_out[i * OUT_NODES + j] = clip_w(w_out[i * OUT_NODES + j]
                  + w_step(longint'(rate_ow), qo[j], h[i]));
         end
         for (int i = 0; i < HIDDEN_NODES; i++) begin
            acc = 0;
            for (int j = 0; j < OUT_NODES; j++) acc += qo[j] * w_out[i * OUT_NODES + j];
            qh[i] = rshift_rnd(rshift_rnd(acc, 30) * (h[i] * (32768 - h[i])), 16);
            for (int j = 0; j < IN_NODES; j++)
               w_in[j * HIDDEN_NODES + i] = clip_w(w_in[j * HIDDEN_NODES + i]
                  + w_step(longint'(rate_iw), qh[i], x[j]));
         end
         for (int j = 0; j < OUT_NODES; j++)
            b_out[j] = clip_w(b_out[j] + rshift_rnd(longint'(rate_ob) * qo[j], 29));
         for (int i = 0; i < HIDDEN_NODES; i++)
            b_hid[i] = clip_w(b_hid[i] + rshift_rnd(longint'(rate_hb) * qh[i], 29));
         err = rshift_rnd(err, 15);
         if (err > 131071) err = 131071;
      end
      r.out_a = y[0][15:0];
      r.out_b = y[1][15:0];
      r.out_c = y[2][15:0];
      r.sq_err = err[16:0];
      expected_q.push_back(r);
   endtask

   task automatic report(string field, longint got, longint want);
      $display("%0t mbt_checker: %s got %0d, want %0d", $realtime, field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      net_result_type r;
      if (reset) begin
         expected_q.delete();
         for (int i = 0; i < N_IW; i++) w_in[i] = 0;
         for (int i = 0; i < N_OW; i++) w_out[i] = 0;
         for (int i = 0; i < HIDDEN_NODES; i++) b_hid[i] = 0;
         for (int i = 0; i < OUT_NODES; i++) b_out[i] = 0;
         rate_iw = RATE_RESET;
         rate_ow = RATE_RESET;
         rate_hb = RATE_RESET;
         rate_ob = RATE_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RATE_IW: rate_iw = csr_data;
               CSR_RATE_OW: rate_ow = csr_data;
               CSR_RATE_HB: rate_hb = csr_data;
               CSR_RATE_OB: rate_ob = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report("unexpected result", 1, 0);
            end else begin
               r = expected_q.pop_front();
               if (rsp_output_a !== r.out_a) report("output_a", rsp_output_a, r.out_a);
               if (rsp_output_b !== r.out_b) report("output_b", rsp_output_b, r.out_b);
               if (rsp_output_c !== r.out_c) report("output_c", rsp_output_c, r.out_c);
               if (rsp_sample_error !== r.sq_err)
                  report("sample_error", rsp_sample_error, r.sq_err);
            end
         end
         if (req_valid && !req_stall) predict_request();
      end
      pending = expected_q.size();
   end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the backprop trainer core
// Drives directed and random inference, training, weight-write and spare-type
// requests under several learning-rate settings with random idle and stall
// bursts; the checker beside the core predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top import mbt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 900000;
   localparam int DRAIN_CYCLES = 80;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = '0;
   logic [15:0]        req_feature_a = '0, req_feature_b = '0;
   logic [15:0]        req_feature_c = '0, req_feature_d = '0;
   logic [15:0]        req_target_a = '0, req_target_b = '0, req_target_c = '0;
   logic [6:0]         req_weight_index = '0;
   logic signed [23:0] req_weight_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [15:0]        rsp_output_a, rsp_output_b, rsp_output_c;
   logic [16:0]        rsp_sample_error;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;
   int                 errors, pending;
   int                 cycles = 0;
   int                 stall_left = 0;
   bit                 quiet = 1'b0;

   localparam logic [1:0] REQ_INFER = 2'd0;
   localparam logic [1:0] REQ_SPARE = 2'd3;

   always #2 clock = ~clock;

   mlp_backprop_trainer_core uut (.*);

   mbt_checker chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 11) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send(logic [1:0] kind, logic [15:0] fa, fb, fc, fd, ta, tbv, tc,
                       logic [6:0] idx, logic signed [23:0] val);
      req_type <= kind;
      req_feature_a <= fa;
      req_feature_b <= fb;
      req_feature_c <= fc;
      req_feature_d <= fd;
      req_target_a <= ta;
      req_target_b <= tbv;
      req_target_c <= tc;
      req_weight_index <= idx;
      req_weight_value <= val;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_sender(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(logic [1:0] idx, logic [15:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_rates(logic [15:0] iw, ow, hb, ob);
      write_rate(CSR_RATE_IW, iw);
      write_rate(CSR_RATE_OW, ow);
      write_rate(CSR_RATE_HB, hb);
      write_rate(CSR_RATE_OB, ob);
   endtask

   function automatic logic [15:0] rand_unit();
      if ($urandom_range(0, 19) == 0) return 16'($urandom);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 16'd32768 : 16'd0;
      return 16'($urandom_range(0, 32768));
   endfunction

   task automatic random_item();
      logic [1:0]         kind;
      logic [6:0]         idx;
      logic signed [23:0] val;
      int                 pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = REQ_WRITE;
      else if (pick < 70) kind = REQ_TRAIN;
      else if (pick < 95) kind = REQ_INFER;
      else kind = REQ_SPARE;
      idx = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 82));
      if ($urandom_range(0, 7) == 0) val = 24'($urandom);
      else val = 24'($signed($urandom_range(0, 262143)) - 131072);
      send(kind, rand_unit(), rand_unit(), rand_unit(), rand_unit(),
           rand_unit(), rand_unit(), rand_unit(), idx, val);
      if (!quiet && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 18));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(REQ_INFER, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 24'sd0);
      send(REQ_WRITE, 16'd32768, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
           7'd0, 24'sh7FFFFF);
      send(REQ_WRITE, 16'd32768, 16'd32768, 16'd32768, 16'd32768, 16'd0, 16'd0, 16'd0,
           7'd45, -24'sd8388608);
      send(REQ_WRITE, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
           7'd82, 24'sd65536);
      send(REQ_WRITE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd72, -24'sd131072);
      send(REQ_WRITE, 16'd1, 16'd2, 16'd3, 16'd4, 16'd0, 16'd0, 16'd0, 7'd83, 24'sd12345);
      send(REQ_WRITE, 16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd127, 24'sd1);
      send(REQ_INFER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
           7'd5, 24'sd99);
      send(REQ_TRAIN, 16'd32768, 16'd32768, 16'd0, 16'd0, 16'd32768, 16'd0, 16'd32768,
           7'd0, 24'sd0);
      send(REQ_TRAIN, 16'd0, 16'd32768, 16'd32768, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 24'sd0);
      send(REQ_TRAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
           16'hFFFF, 7'd0, 24'sd0);
      send(REQ_SPARE, 16'd8000, 16'd9000, 16'd10000, 16'd11000, 16'd0, 16'd0, 16'd0,
           7'd3, 24'sd7);
      send(REQ_TRAIN, 16'd20000, 16'd10000, 16'd5000, 16'd30000, 16'd32768, 16'd32768,
           16'd32768, 7'd0, 24'sd0);
      send(REQ_INFER, 16'd20000, 16'd10000, 16'd5000, 16'd30000, 16'd0, 16'd0, 16'd0,
           7'd0, 24'sd0);
      drain();

      set_rates(16'd0, 16'd0, 16'd0, 16'd0);
      repeat (200) random_item();
      drain();

      set_rates(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (200) random_item();
      drain();

      set_rates(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      repeat (150) random_item();
      pause_sender(1);
      while (pending != 0) @(posedge clock);
      repeat (150) random_item();
      drain();

      set_rates(RATE_RESET, 16'd1000, 16'd40000, 16'd1);
      repeat (200) random_item();
      quiet = 1'b1;
      repeat (150) random_item();
      drain();

      if (errors == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule

// File: mlp_backprop_trainer_core.f
hdl/mbt_pkg.sv
hdl/mbt_lane.sv
hdl/mbt_merge.sv
hdl/mlp_backprop_trainer_core.sv
verif/mbt_checker.sv
verif/tb_top.sv
